// ===== rtl/core/goldbach_pair_counter_assert.svh =====
// Assertion macros used by the checker file of the pair counter.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GOLDBACH_PAIR_COUNTER_ASSERT_SVH
`define GOLDBACH_PAIR_COUNTER_ASSERT_SVH

// Same-cycle implication, quiet while reset is high
`define GPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high
`define GPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset
`define GPC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gpc_pkg.sv =====
// Shared constants of the Goldbach pair counter: field widths and defaults.
// No dependencies; used by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package gpc_pkg;

  // Default sieve limit
  localparam int unsigned MAX_N_DEFAULT = 65536;

  // Payload field widths
  localparam int unsigned NUMBER_W = 16;
  localparam int unsigned COUNT_W  = 15;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // Upper bound on the count any 16-bit number can produce
  localparam int unsigned COUNT_MAX = 16384;

endpackage

// ===== rtl/core/gpc_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gpc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/goldbach_pair_counter.sv =====
// Goldbach pair counter. After reset the block clears its one-bit-per-odd-number map
// (no transfer taken) and then runs a sieve of Eratosthenes over it, marking the odd
// multiples of each odd candidate whose square is below MAX_N; s_tready stays low until
// the sieve is done. A number n then returns the count of unordered prime pairs summing
// to n. For even n of 6 and up the block reads the map at p and n-p on its two read
// ports every cycle for each odd p from 3 up to n/2; odd n and n below 6 skip it.
// The finished count waits in an output register, so the next number is taken while
// the previous result is still unread.
// Depends on gpc_pkg and gpc_ram.
`timescale 1ns / 1ps

module goldbach_pair_counter #(
  parameter int unsigned MAX_N = gpc_pkg::MAX_N_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata: [15:0] number
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gpc_pkg::IN_TDATA_W-1:0]   s_tdata,
  // m_tdata: [14:0] pair_count, [15] zero
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gpc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  localparam int unsigned MAP_DEPTH = (MAX_N + 1) / 2;
  localparam int unsigned AW = $clog2(MAP_DEPTH);
  localparam int unsigned VW = $clog2(MAX_N) + 3;
  localparam int unsigned XW = (AW > 15) ? AW : 15;
  localparam int unsigned NW = gpc_pkg::NUMBER_W;
  localparam int unsigned CW = gpc_pkg::COUNT_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_S_RD   = 3'd1;
  localparam logic [2:0] ST_S_CHK  = 3'd2;
  localparam logic [2:0] ST_S_MARK = 3'd3;
  localparam logic [2:0] ST_IDLE   = 3'd4;
  localparam logic [2:0] ST_QUERY  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  // Map index of an odd number, and whether it lies inside the map
  function automatic logic [AW-1:0] map_addr(input logic [NW-1:0] x);
    logic [XW-1:0] idx;
    idx = XW'(x[NW-1:1]);
    return idx[AW-1:0];
  endfunction

  function automatic logic in_map(input logic [NW-1:0] x);
    logic [XW:0] idx;
    idx = (XW+1)'(x[NW-1:1]);
    return idx < (XW+1)'(MAP_DEPTH);
  endfunction

  logic [2:0]    state;
  logic [AW-1:0] clr_cnt;
  logic [VW-1:0] sp;
  logic [VW-1:0] psq;
  logic [VW-1:0] mult;
  logic [NW-1:0] num;
  logic [NW-2:0] half;
  logic [NW-1:0] qp;
  logic [CW-1:0] count;
  logic          pend;
  logic          pend_single;
  logic          pend_ok_a;
  logic          pend_ok_b;

  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic          rdata_a;
  logic          rdata_b;

  logic [NW-1:0] in_num;
  logic [NW-1:0] in_rest;
  logic [NW-1:0] q_rest;
  logic [VW-1:0] mult_next;
  logic          hit;
  logic [CW-1:0] count_upd;
  logic          out_free;

  assign in_num    = s_tdata[NW-1:0];
  assign in_rest   = in_num - NW'(2);
  assign q_rest    = num - qp;
  assign mult_next = mult + {sp[VW-2:0], 1'b0};
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);

  // Score the lookup issued last cycle
  assign hit       = pend && pend_ok_a && !rdata_a &&
                     (pend_single || (pend_ok_b && !rdata_b));
  assign count_upd = count + CW'(hit);

  // Map port selection
  always_comb begin
    we      = 1'b0;
    waddr   = mult[AW:1];
    wdata   = 1'b1;
    raddr_a = map_addr(qp);
    raddr_b = map_addr(q_rest);
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = (clr_cnt == '0);
      end
      ST_S_RD: begin
        raddr_a = sp[AW:1];
      end
      ST_S_MARK: begin
        we = 1'b1;
      end
      ST_IDLE: begin
        raddr_a = map_addr(in_rest);
      end
      default: begin
      end
    endcase
  end

  gpc_ram #(
    .WIDTH(1),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Sieve and query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      pend    <= 1'b0;
    end else begin
      pend <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MAP_DEPTH - 1)) begin
            sp    <= VW'(3);
            psq   <= VW'(9);
            state <= ST_S_RD;
          end
        end
        ST_S_RD: begin
          if (psq >= VW'(MAX_N)) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_S_CHK;
          end
        end
        ST_S_CHK: begin
          if (!rdata_a) begin
            mult  <= psq;
            state <= ST_S_MARK;
          end else begin
            sp    <= sp + VW'(2);
            psq   <= psq + {sp[VW-3:0], 2'b00} + VW'(4);
            state <= ST_S_RD;
          end
        end
        ST_S_MARK: begin
          mult <= mult_next;
          if (mult_next >= VW'(MAX_N)) begin
            sp    <= sp + VW'(2);
            psq   <= psq + {sp[VW-3:0], 2'b00} + VW'(4);
            state <= ST_S_RD;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            num   <= in_num;
            half  <= in_num[NW-1:1];
            qp    <= NW'(3);
            count <= CW'(in_num == NW'(4));
            if (in_num < NW'(4)) begin
              state <= ST_FINISH;
            end else if (in_num[0]) begin
              // Odd number: only the pair with 2 can count
              pend        <= 1'b1;
              pend_single <= 1'b1;
              pend_ok_a   <= in_map(in_rest);
              state       <= ST_FINISH;
            end else begin
              state <= ST_QUERY;
            end
          end
        end
        ST_QUERY: begin
          count <= count_upd;
          if (qp <= {1'b0, half}) begin
            pend        <= 1'b1;
            pend_single <= 1'b0;
            pend_ok_a   <= in_map(qp);
            pend_ok_b   <= in_map(q_rest);
            qp          <= qp + NW'(2);
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          count <= count_upd;
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tdata <= gpc_pkg::OUT_TDATA_W'(count_upd);
    end
  end

endmodule

// ===== rtl/core/gpc_checker.sv =====
// Port-level checks of the Goldbach pair counter, bound to the top level.
// Depends on gpc_pkg and goldbach_pair_counter_assert.svh.
`timescale 1ns / 1ps
`include "goldbach_pair_counter_assert.svh"

module gpc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [gpc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // Hold a stalled result
  `GPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

  // Count stays within what a 16-bit number can reach, pad bit zero
  `GPC_ASSERT_NOW(a_count_range, m_tvalid, m_tdata <= gpc_pkg::OUT_TDATA_W'(gpc_pkg::COUNT_MAX), "count out of range")

  // Sieve runs after reset before any number is taken
  `GPC_ASSERT_NEXT_ALWAYS(a_sieve_busy, rst, !s_tready, "input ready right after reset")

  // One number at a time
  `GPC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input ready right after a transfer")

endmodule

bind goldbach_pair_counter gpc_checker u_gpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/tb.sv =====
// Testbench for goldbach_pair_counter: streams numbers in, checks each pair count
// against a local sieve and pair count. Depends on gpc_pkg and the counter RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SIEVE_LIMIT = gpc_pkg::MAX_N_DEFAULT;
  localparam int unsigned ODD_DEPTH   = (SIEVE_LIMIT + 1) / 2;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [gpc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [gpc_pkg::OUT_TDATA_W-1:0] m_tdata;

  // Odd-only composite flags: entry i stands for 2i+1
  bit                              odd_is_composite [ODD_DEPTH];

  logic [gpc_pkg::NUMBER_W-1:0]    number_q [$];
  logic [gpc_pkg::COUNT_W-1:0]     pair_count_q [$];
  logic                            in_done = 1'b0;
  int unsigned                     error_count = 0;
  longint unsigned                 cycle_count = 0;
  longint unsigned                 cycle_limit = 0;

  // Sender burst and receiver stall state
  int unsigned                     burst_left = 0;
  int unsigned                     gap_left = 0;
  int unsigned                     stall_left = 0;
  int unsigned                     rx_tick = 0;

  goldbach_pair_counter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Build the composite flags with a sieve over odd numbers
  task automatic sieve_odd_numbers();
    int unsigned p;
    int unsigned m;
    for (int unsigned i = 0; i < ODD_DEPTH; i++) odd_is_composite[i] = 1'b0;
    for (p = 3; p * p < SIEVE_LIMIT; p += 2) begin
      if (!odd_is_composite[p >> 1]) begin
        for (m = p * p; m < SIEVE_LIMIT; m += 2 * p) odd_is_composite[m >> 1] = 1'b1;
      end
    end
    odd_is_composite[0] = 1'b1;
  endtask

  // x is odd; entries past the map count as composite
  function automatic bit odd_prime(input int unsigned x);
    if ((x >> 1) >= ODD_DEPTH) return 1'b0;
    return !odd_is_composite[x >> 1];
  endfunction

  // Count unordered prime pairs p <= q with p + q = n
  function automatic logic [gpc_pkg::COUNT_W-1:0] goldbach_pairs(
    input logic [gpc_pkg::NUMBER_W-1:0] n
  );
    int unsigned total;
    int unsigned rest;
    int unsigned p;
    total = 0;
    if (n >= 4) begin
      rest = n - 2;
      if (rest == 2) total++;
      else if ((rest & 1) != 0 && odd_prime(rest)) total++;
      for (p = 3; p <= n / 2; p += 2) begin
        rest = n - p;
        if (odd_prime(p) && (rest & 1) != 0 && odd_prime(rest)) total++;
      end
    end
    return total[gpc_pkg::COUNT_W-1:0];
  endfunction

  // Stimulus, time budget and end of run
  initial begin
    logic [gpc_pkg::NUMBER_W-1:0] directed [] = '{
      16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd9,
      16'd10, 16'd11, 16'd100, 16'd65535, 16'd65534, 16'd65523, 16'd65532,
      16'd32768, 16'd32767, 16'h5555, 16'hAAAA, 16'd2048
    };
    longint unsigned work;
    sieve_odd_numbers();
    foreach (directed[k]) number_q.insert(number_q.size(), directed[k]);
    // Mostly small numbers keep the walk short; a few span the full range
    for (int k = 0; k < 78; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        number_q.insert(number_q.size(), 16'($urandom_range(0, 65535)));
      end else begin
        number_q.insert(number_q.size(), 16'($urandom_range(0, 4095)));
      end
    end
    work = 100000;
    foreach (number_q[k]) work += number_q[k] / 4 + 3 + 21 + 31 + 8;
    cycle_limit = 4 * work;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    while (number_q.size() != 0 || pair_count_q.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= cycle_limit && cycle_limit != 0) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Driver: present numbers in bursts, hold each until its transfer
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (in_done) begin
        void'(number_q.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      if (!s_tvalid || in_done) begin
        if (gap_left > 0) begin
          s_tvalid <= 1'b0;
          gap_left--;
        end else if (number_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= number_q[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that rotates between calm, choppy and long stalls
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        case ((rx_tick / 256) % 4)
          1: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 30);
          default: stall_left = 0;
        endcase
      end
    end
  end

  // Monitor: check results, then queue the count for each accepted number
  always @(posedge clk) begin
    if (rst) begin
      in_done <= 1'b0;
    end else begin
      in_done <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (pair_count_q.size() == 0) begin
          $error("pair_count: unexpected result %0d", m_tdata[gpc_pkg::COUNT_W-1:0]);
          error_count++;
        end else begin
          if (m_tdata[gpc_pkg::COUNT_W-1:0] !== pair_count_q[0]) begin
            $error("pair_count mismatch: expected %0d, actual %0d",
                   pair_count_q[0], m_tdata[gpc_pkg::COUNT_W-1:0]);
            error_count++;
          end
          pair_count_q.delete(0);
        end
      end
      if (s_tvalid && s_tready) begin
        pair_count_q.insert(pair_count_q.size(), goldbach_pairs(s_tdata));
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gpc_pkg.sv
rtl/core/gpc_ram.sv
rtl/core/goldbach_pair_counter.sv
rtl/core/gpc_checker.sv
sim/tb.sv
